// ===== hdl/nmea_sentence_field_extractor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA field extractor assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NSFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA field extractor package
// Shared constants, types and helpers for the sentence parser and replay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsfe_pkg;

    localparam int CAPTURE_DEPTH = 32;
    localparam int CAP_AW        = $clog2(CAPTURE_DEPTH);
    localparam int CNT_W         = $clog2(CAPTURE_DEPTH + 1);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam logic [39:0] SENTENCE_TYPE_RESET = 40'h4750524D43;
    localparam logic [4:0]  FIRST_FIELD_RESET   = 5'd3;
    localparam logic [4:0]  LAST_FIELD_RESET    = 5'd6;

    localparam logic [1:0] CFG_SENTENCE_TYPE = 2'd0;
    localparam logic [1:0] CFG_FIRST_FIELD   = 2'd1;
    localparam logic [1:0] CFG_LAST_FIELD    = 2'd2;

    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_MISMATCH = 2'd1;
    localparam logic [1:0] KIND_EMPTY    = 2'd2;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_EMPTY,
        CMD_REPLAY
    } cmd_kind_t;

    typedef struct packed {
        logic [39:0] sentence_type;
        logic [4:0]  first_field;
        logic [4:0]  last_field;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [CAP_AW-1:0] addr;
        logic [4:0]        field;
        logic [7:0]        ch;
    } cap_wr_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [CNT_W-1:0] count;
        logic             drop;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic has_replay;
    } q_status_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

// ===== hdl/nmea_sentence_field_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence field extractor
// Parses an NMEA 0183 byte stream and replays the characters of a chosen
// field range of a chosen sentence type, after a checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   word. A byte is taken every cycle unless a replay or full queue blocks it.
//   Output channel (out_valid/out_ready) gives one result word per cycle
//   at best: kind, field number, character, overflow and last-of-run flag.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; index 0 sentence type, 1 first field, 2 last field.
//   A sentence end with a bad checksum or of the chosen type pushes a
//   command into a two-entry queue; results leave through an output register.
//   A replay does one store read and one output load per captured character;
//   the input is held off until the replay is done, since the next sentence
//   refills the same capture store.
//   Error and empty results do not hold off input.
//   A stalled receiver holds the output word; a pending replay then holds off
//   input, and error or empty commands stop it once two are pending.
//   Reset returns the parser to idle and the registers to their defaults;
//   the capture store is not cleared, only filled entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_sentence_field_extractor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [4:0]  field_number,
    output logic [7:0]  field_char,
    output logic        overflowed,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    nsfe_pkg::cfg_t      cfg_reg;
    nsfe_pkg::cap_wr_t   cap_wr;
    nsfe_pkg::cmd_t      push_cmd;
    nsfe_pkg::cmd_t      head;
    nsfe_pkg::q_status_t q_status;
    logic                push;
    logic                pop;
    logic                back_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sentence_type <= nsfe_pkg::SENTENCE_TYPE_RESET;
            cfg_reg.first_field   <= nsfe_pkg::FIRST_FIELD_RESET;
            cfg_reg.last_field    <= nsfe_pkg::LAST_FIELD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to unused indexes
            if (cfg_index == nsfe_pkg::CFG_SENTENCE_TYPE) cfg_reg.sentence_type <= cfg_data;
            if (cfg_index == nsfe_pkg::CFG_FIRST_FIELD)   cfg_reg.first_field <= cfg_data[4:0];
            if (cfg_index == nsfe_pkg::CFG_LAST_FIELD)    cfg_reg.last_field  <= cfg_data[4:0];
        end
    end

    nsfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .back_busy (back_busy),
        .cap_wr    (cap_wr),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    nsfe_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    nsfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cap_wr       (cap_wr),
        .head         (head),
        .q_empty      (q_status.empty),
        .pop          (pop),
        .busy         (back_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .field_number (field_number),
        .field_char   (field_char),
        .overflowed   (overflowed),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== hdl/nsfe_front.sv =====
// ----------------------------------------------------------------------------
// NMEA field extractor front end
// Parses bytes, checks header and checksum, writes captured characters and
// issues a finish command per bad-checksum or chosen-type sentence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsfe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  nsfe_pkg::cfg_t      cfg,
    input  nsfe_pkg::q_status_t q_status,
    input  logic                back_busy,
    output nsfe_pkg::cap_wr_t   cap_wr,
    output logic                push,
    output nsfe_pkg::cmd_t      push_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_CK_HI,
        PH_CK_LO
    } phase_t;

    phase_t                     phase_reg;
    logic [7:0]                 xor_reg;
    logic [4:0]                 comma_reg;
    logic [39:0]                header_reg;
    logic [2:0]                 hcnt_reg;
    logic [3:0]                 hi_nib_reg;
    logic [nsfe_pkg::CNT_W-1:0] fill_reg;
    logic                       drop_reg;

    logic       acc;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       in_range;
    logic       room;
    logic       header_ok;
    logic [4:0] hex;

    // hold off input on a full queue or while a replay owns the store
    assign in_ready  = !q_status.full && !q_status.has_replay && !back_busy;
    assign acc       = in_valid && in_ready;
    assign is_dollar = (rx_byte == nsfe_pkg::CHAR_DOLLAR);
    assign is_star   = (rx_byte == nsfe_pkg::CHAR_STAR);
    assign is_comma  = (rx_byte == nsfe_pkg::CHAR_COMMA);
    assign in_range  = (comma_reg >= cfg.first_field) && (comma_reg <= cfg.last_field);
    assign room      = (fill_reg < nsfe_pkg::CNT_W'(nsfe_pkg::CAPTURE_DEPTH));
    assign header_ok = (hcnt_reg == 3'd5) && (header_reg == cfg.sentence_type);
    assign hex       = nsfe_pkg::hex_value(rx_byte);

    always_comb
    begin
        cap_wr.en    = acc && !is_dollar && (phase_reg == PH_BODY) && !is_star
                       && !is_comma && in_range && room;
        cap_wr.addr  = fill_reg[nsfe_pkg::CAP_AW-1:0];
        cap_wr.field = comma_reg;
        cap_wr.ch    = rx_byte;

        push           = 1'b0;
        push_cmd.kind  = nsfe_pkg::CMD_ERROR;
        push_cmd.count = fill_reg;
        push_cmd.drop  = drop_reg;
        if (acc && !is_dollar)
        begin
            if (phase_reg == PH_CK_HI && !hex[4])
            begin
                push = 1'b1;
            end
            else if (phase_reg == PH_CK_LO)
            begin
                if (!hex[4] || ({hi_nib_reg, hex[3:0]} != xor_reg))
                begin
                    push = 1'b1;
                end
                else if (header_ok)
                begin
                    push          = 1'b1;
                    push_cmd.kind = (fill_reg == '0) ? nsfe_pkg::CMD_EMPTY
                                                     : nsfe_pkg::CMD_REPLAY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= '0;
            comma_reg  <= '0;
            header_reg <= '0;
            hcnt_reg   <= '0;
            hi_nib_reg <= '0;
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
        end
        else if (acc)
        begin
            if (is_dollar)
            begin
                // restart, abandoning any open sentence
                phase_reg  <= PH_BODY;
                xor_reg    <= '0;
                comma_reg  <= '0;
                header_reg <= '0;
                hcnt_reg   <= '0;
                hi_nib_reg <= '0;
                fill_reg   <= '0;
                drop_reg   <= 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_reg <= PH_IDLE;
                    end
                    PH_BODY:
                    begin
                        if (is_star)
                        begin
                            phase_reg <= PH_CK_HI;
                        end
                        else
                        begin
                            xor_reg <= xor_reg ^ rx_byte;
                            if (is_comma)
                            begin
                                if (comma_reg != 5'd31) comma_reg <= comma_reg + 5'd1;
                            end
                            else
                            begin
                                if (comma_reg == 5'd0)
                                begin
                                    header_reg <= {header_reg[31:0], rx_byte};
                                    if (hcnt_reg != 3'd6) hcnt_reg <= hcnt_reg + 3'd1;
                                end
                                if (in_range)
                                begin
                                    if (room) fill_reg <= fill_reg + nsfe_pkg::CNT_W'(1);
                                    else      drop_reg <= 1'b1;
                                end
                            end
                        end
                    end
                    PH_CK_HI:
                    begin
                        if (hex[4])
                        begin
                            hi_nib_reg <= hex[3:0];
                            phase_reg  <= PH_CK_LO;
                        end
                        else
                        begin
                            phase_reg <= PH_IDLE;
                        end
                    end
                    PH_CK_LO:
                    begin
                        phase_reg <= PH_IDLE;
                    end
                    default:
                    begin
                        phase_reg <= PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/nsfe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// NMEA field extractor command queue
// Two-entry queue of finish commands between the parser and the replay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsfe_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nsfe_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output nsfe_pkg::cmd_t      head,
    output nsfe_pkg::q_status_t status
);

    nsfe_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign head = slot_reg[rd_ptr_reg];

    always_comb
    begin
        status.full       = (count_reg == 2'd2);
        status.empty      = (count_reg == 2'd0);
        status.has_replay = ((count_reg != 2'd0)
                             && (slot_reg[rd_ptr_reg].kind == nsfe_pkg::CMD_REPLAY))
                            || ((count_reg == 2'd2)
                             && (slot_reg[!rd_ptr_reg].kind == nsfe_pkg::CMD_REPLAY));
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hdl/nsfe_back.sv =====
// ----------------------------------------------------------------------------
// NMEA field extractor back end
// Holds the capture store and turns finish commands into result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  nsfe_pkg::cap_wr_t cap_wr,
    input  nsfe_pkg::cmd_t    head,
    input  logic              q_empty,
    output logic              pop,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic [4:0]        field_number,
    output logic [7:0]        field_char,
    output logic              overflowed,
    output logic              last_of_run
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } state_t;

    logic [12:0] mem [nsfe_pkg::CAPTURE_DEPTH];
    logic [12:0] rd_data_reg;

    state_t                     state_reg;
    logic [nsfe_pkg::CNT_W-1:0] idx_reg;
    logic [nsfe_pkg::CNT_W-1:0] cnt_reg;
    logic                       drop_reg;
    logic                       out_valid_reg;
    logic [1:0]                 kind_reg;
    logic [4:0]                 field_reg;
    logic [7:0]                 char_reg;
    logic                       ovf_reg;
    logic                       last_reg;

    logic out_free;
    logic out_load;
    logic at_last;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && !q_empty && out_free;
    assign busy     = (state_reg != S_IDLE);
    assign at_last  = ((idx_reg + nsfe_pkg::CNT_W'(1)) == cnt_reg);
    // load a new word into the output register this cycle
    assign out_load = (pop && (head.kind != nsfe_pkg::CMD_REPLAY))
                      || ((state_reg == S_SEND) && out_free);

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign field_number = field_reg;
    assign field_char   = char_reg;
    assign overflowed   = ovf_reg;
    assign last_of_run  = last_reg;

    always_ff @(posedge clk)
    begin
        if (cap_wr.en) mem[cap_wr.addr] <= {cap_wr.field, cap_wr.ch};
        rd_data_reg <= mem[idx_reg[nsfe_pkg::CAP_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= nsfe_pkg::KIND_CHAR;
            field_reg     <= '0;
            char_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)       out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.kind == nsfe_pkg::CMD_REPLAY)
                        begin
                            idx_reg   <= '0;
                            cnt_reg   <= head.count;
                            drop_reg  <= head.drop;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            kind_reg      <= (head.kind == nsfe_pkg::CMD_EMPTY)
                                             ? nsfe_pkg::KIND_EMPTY
                                             : nsfe_pkg::KIND_MISMATCH;
                            field_reg     <= '0;
                            char_reg      <= '0;
                            ovf_reg       <= head.drop;
                            last_reg      <= 1'b1;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= nsfe_pkg::KIND_CHAR;
                        field_reg     <= rd_data_reg[12:8];
                        char_reg      <= rd_data_reg[7:0];
                        ovf_reg       <= drop_reg;
                        last_reg      <= at_last;
                        if (at_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + nsfe_pkg::CNT_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/nsfe_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA field extractor port checker
// Concurrent checks on the top level's output channel, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nmea_sentence_field_extractor_unit_defines.svh"

module nsfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] result_kind,
    input logic [4:0] field_number,
    input logic [7:0] field_char,
    input logic       overflowed,
    input logic       last_of_run
);

    `NSFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_kind) && $stable(field_number)
        && $stable(field_char) && $stable(overflowed) && $stable(last_of_run),
        "stalled result word changed")

    `NSFE_ASSERT_NOW(a_kind_legal, out_valid,
        result_kind == nsfe_pkg::KIND_CHAR || result_kind == nsfe_pkg::KIND_MISMATCH
        || result_kind == nsfe_pkg::KIND_EMPTY,
        "illegal result kind")

    `NSFE_ASSERT_NOW(a_single_zero, out_valid && result_kind != nsfe_pkg::KIND_CHAR,
        field_number == 5'd0 && field_char == 8'd0,
        "non-character result carries field data")

    `NSFE_ASSERT_NOW(a_single_last, out_valid && result_kind != nsfe_pkg::KIND_CHAR,
        last_of_run, "single result not marked last")

endmodule

bind nmea_sentence_field_extractor_unit nsfe_checker u_nsfe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .field_number (field_number),
    .field_char   (field_char),
    .overflowed   (overflowed),
    .last_of_run  (last_of_run)
);
